// ----- hdl/separable_gaussian_blur_defines.svh -----
// assertion macros for the separable blur
`ifndef SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SGB_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgb check failed");

// next-cycle implication, checked out of reset
`define SGB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgb check failed");

`endif

// ----- hdl/sgb_pkg.sv -----
// shared constants and helpers for the separable blur
package sgb_pkg;

  localparam int HalfTaps  = 5;
  localparam int StoreRows = 2 * HalfTaps;
  localparam int MinSize   = 6;
  localparam int AccW      = 28;
  localparam int DefMaxWidth  = 1024;
  localparam int DefMaxHeight = 1024;

  localparam logic [3:0] RegWidth   = 4'd0;
  localparam logic [3:0] RegHeight  = 4'd1;
  localparam logic [3:0] RegWeight0 = 4'd2;
  localparam logic [3:0] RegWeight5 = 4'd7;

  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [10:0] HeightReset = 11'd480;
  localparam logic [15:0] WeightReset [HalfTaps+1] =
    '{16'd7168, 16'd7026, 16'd6617, 16'd5988, 16'd5205, 16'd4348};

  typedef logic [AccW-1:0] acc_t;

  // drop the q0.16 fraction and clip at full scale
  function automatic logic [7:0] scale_sat(input acc_t acc);
    logic [AccW-17:0] whole;
    whole = acc[AccW-1:16];
    if (whole > (AccW-16)'(255)) begin
      return 8'hff;
    end
    return whole[7:0];
  endfunction

endpackage

// ----- hdl/separable_gaussian_blur.sv -----
// separable 11-tap blur: top level with row store, column buffer and sequencer
//
// Streams 8-bit grey pixels in raster order (action 0) and returns the 11-tap
// blurred image, vertical pass first then horizontal, both with mirrored
// borders that repeat the edge pixel. Output row r appears while input
// row r+5 streams in; after the last pixel, drain requests (action 1) flush the
// last five rows, one column each. One request is handled at a time: the input
// stalls until its results are delivered. A request that needs a vertical sum is
// accepted in the idle state, steps its 11 taps through one multiplier and the
// one read port of the row store, then writes the column; each of its up to six
// results steps 11 taps through the column buffer read port and waits for the
// output handshake, and the position update ends the request. A pixel of the
// first five rows is only stored and counted; a dropped request changes nothing.
// A pending register write holds off input requests.
// There is no clearing pass. Writing the width or height restarts the frame.
`include "separable_gaussian_blur_defines.svh"

module separable_gaussian_blur
  import sgb_pkg::*;
#(
  parameter int MAX_WIDTH  = DefMaxWidth,
  parameter int MAX_HEIGHT = DefMaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel / drain requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  pixel_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blurred_o,
  output logic [9:0]  out_row_o,
  output logic [9:0]  out_col_o,
  output logic        frame_done_o,
  output logic        last_of_run_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int RowW    = $clog2(MAX_HEIGHT + 1);
  localparam int ColW    = $clog2(MAX_WIDTH + 1);
  localparam int ColAW   = $clog2(MAX_WIDTH);
  localparam int RsDepth = StoreRows * MAX_WIDTH;
  localparam int RsAW    = $clog2(RsDepth);
  localparam int DimW    = (RowW > ColW) ? RowW : ColW;
  localparam int SW      = ((DimW > 11) ? DimW : 11) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_VADDR, S_VMUL, S_VACC, S_VWR, S_HADDR, S_HMUL, S_HACC, S_OUT, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [10:0] image_width_q, image_height_q;
  logic [15:0] weights_q [HalfTaps+1];

  // positions
  logic [RowW-1:0] in_row_q, emit_row_q;
  logic [ColW-1:0] in_col_q, emit_col_q;
  logic [3:0]      in_m10_q, emit_m10_q;

  // datapath
  logic            is_pixel_q, did_vert_q, cur_q;
  logic [7:0]      pixel_q;
  logic signed [4:0] tap_k_q;
  logic [15:0]     wt_q;
  logic [23:0]     prod_q;
  acc_t            acc_q;
  logic [ColW-1:0] hx_q, hlast_q;

  // memories
  logic [7:0] rs_mem [RsDepth];
  logic [7:0] vr_mem [MAX_WIDTH];
  logic [7:0] rs_rdata_q, vr_rdata_q;

  // clamped frame size
  logic signed [SW-1:0] w_ext, h_ext;
  logic [ColW-1:0] w_cl;
  logic [RowW-1:0] h_cl;

  always_comb begin
    w_ext = SW'(image_width_q);
    h_ext = SW'(image_height_q);
    if (w_ext < SW'(MinSize)) begin
      w_cl = ColW'(MinSize);
    end else if (w_ext > SW'(MAX_WIDTH)) begin
      w_cl = ColW'(MAX_WIDTH);
    end else begin
      w_cl = ColW'(image_width_q);
    end
    if (h_ext < SW'(MinSize)) begin
      h_cl = RowW'(MinSize);
    end else if (h_ext > SW'(MAX_HEIGHT)) begin
      h_cl = RowW'(MAX_HEIGHT);
    end else begin
      h_cl = RowW'(image_height_q);
    end
  end

  // tap distance selects the weight
  logic [2:0] tap_d;
  assign tap_d = (tap_k_q < 0) ? 3'(-tap_k_q) : 3'(tap_k_q);

  // vertical tap: mirrored row, then its slot in the ten-row store
  logic signed [SW-1:0] v_er, v_h, v_x, v_rr, v_delta;
  logic signed [5:0]    v_m;
  logic [3:0]           rs_m10;
  logic [RsAW-1:0]      rs_raddr, rs_waddr;
  logic                 use_cur;

  always_comb begin
    v_er = SW'(emit_row_q);
    v_h  = SW'(h_cl);
    v_x  = v_er + SW'(tap_k_q);
    if (v_x < 0) begin
      v_rr = -v_x - SW'(1);
    end else if (v_x >= v_h) begin
      v_rr = (v_h <<< 1) - v_x - SW'(1);
    end else begin
      v_rr = v_x;
    end
    // mirrored row lies within five of the output row
    v_delta = v_rr - v_er;
    v_m = $signed({2'b00, emit_m10_q}) + 6'(v_delta);
    if (v_m < 0) begin
      rs_m10 = 4'(v_m + 6'sd10);
    end else if (v_m >= 6'sd10) begin
      rs_m10 = 4'(v_m - 6'sd10);
    end else begin
      rs_m10 = 4'(v_m);
    end
    rs_raddr = RsAW'(int'(rs_m10) * MAX_WIDTH + int'(emit_col_q));
    rs_waddr = RsAW'(int'(in_m10_q) * MAX_WIDTH + int'(in_col_q));
    use_cur  = is_pixel_q && (v_rr == SW'(in_row_q));
  end

  // horizontal tap: mirrored column of the buffer
  logic signed [SW-1:0] h_x, h_w, h_cc;
  logic [ColAW-1:0]     vr_raddr, vr_waddr;

  always_comb begin
    h_w = SW'(w_cl);
    h_x = SW'(hx_q) + SW'(tap_k_q);
    if (h_x < 0) begin
      h_cc = -h_x - SW'(1);
    end else if (h_x >= h_w) begin
      h_cc = (h_w <<< 1) - h_x - SW'(1);
    end else begin
      h_cc = h_x;
    end
    vr_raddr = h_cc[ColAW-1:0];
    vr_waddr = emit_col_q[ColAW-1:0];
  end

  logic rs_we, vr_we;
  logic [7:0] vert_res;
  assign rs_we    = (state_q == S_FIN) && is_pixel_q;
  assign vr_we    = (state_q == S_VWR);
  assign vert_res = scale_sat(acc_q);

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= pixel_q;
    end
    rs_rdata_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vr_we) begin
      vr_mem[vr_waddr] <= vert_res;
    end
    vr_rdata_q <= vr_mem[vr_raddr];
  end

  // position updates
  logic in_col_wrap, emit_col_wrap, emit_row_end;
  acc_t acc_sum;
  assign in_col_wrap   = (in_col_q + ColW'(1)) >= w_cl;
  assign emit_col_wrap = (emit_col_q + ColW'(1)) >= w_cl;
  assign emit_row_end  = (emit_row_q + RowW'(1)) >= h_cl;
  assign acc_sum       = acc_q + AccW'(prod_q);

  // a register write takes the idle cycle, so the input waits for it
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
      for (int i = 0; i <= HalfTaps; i++) begin
        weights_q[i] <= WeightReset[i];
      end
      in_row_q      <= '0;
      in_col_q      <= '0;
      in_m10_q      <= '0;
      emit_row_q    <= '0;
      emit_col_q    <= '0;
      emit_m10_q    <= '0;
      is_pixel_q    <= 1'b0;
      did_vert_q    <= 1'b0;
      cur_q         <= 1'b0;
      pixel_q       <= '0;
      tap_k_q       <= '0;
      wt_q          <= '0;
      prod_q        <= '0;
      acc_q         <= '0;
      hx_q          <= '0;
      hlast_q       <= '0;
      out_valid_o   <= 1'b0;
      blurred_o     <= '0;
      out_row_o     <= '0;
      out_col_o     <= '0;
      frame_done_o  <= 1'b0;
      last_of_run_o <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == RegWidth || cfg_index_i == RegHeight) begin
              if (cfg_index_i == RegWidth) begin
                image_width_q <= cfg_data_i[10:0];
              end else begin
                image_height_q <= cfg_data_i[10:0];
              end
              in_row_q   <= '0;
              in_col_q   <= '0;
              in_m10_q   <= '0;
              emit_row_q <= '0;
              emit_col_q <= '0;
              emit_m10_q <= '0;
            end else if (cfg_index_i >= RegWeight0 && cfg_index_i <= RegWeight5) begin
              weights_q[3'(cfg_index_i - RegWeight0)] <= cfg_data_i;
            end
          end else if (in_valid_i) begin
            pixel_q    <= pixel_i;
            is_pixel_q <= !action_i;
            tap_k_q    <= -5'sd5;
            acc_q      <= '0;
            if (!action_i) begin
              // pixels after the frame's last one are dropped
              if (in_row_q < h_cl) begin
                if (in_row_q >= RowW'(HalfTaps)) begin
                  did_vert_q <= 1'b1;
                  state_q    <= S_VADDR;
                end else begin
                  did_vert_q <= 1'b0;
                  state_q    <= S_FIN;
                end
              end
            end else if (in_row_q >= h_cl) begin
              // drain only once the whole frame is in
              did_vert_q <= 1'b1;
              state_q    <= S_VADDR;
            end
          end
        end
        S_VADDR: begin
          wt_q    <= weights_q[tap_d];
          cur_q   <= use_cur;
          state_q <= S_VMUL;
        end
        S_VMUL: begin
          prod_q  <= wt_q * (cur_q ? pixel_q : rs_rdata_q);
          state_q <= S_VACC;
        end
        S_VACC: begin
          acc_q <= acc_sum;
          if (tap_k_q == 5'sd5) begin
            state_q <= S_VWR;
          end else begin
            tap_k_q <= tap_k_q + 5'sd1;
            state_q <= S_VADDR;
          end
        end
        S_VWR: begin
          // column written this cycle completes the output five to its left
          tap_k_q <= -5'sd5;
          acc_q   <= '0;
          if (emit_col_q >= ColW'(HalfTaps)) begin
            hx_q    <= emit_col_q - ColW'(HalfTaps);
            hlast_q <= emit_col_wrap ? emit_col_q : emit_col_q - ColW'(HalfTaps);
            state_q <= S_HADDR;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_HADDR: begin
          wt_q    <= weights_q[tap_d];
          state_q <= S_HMUL;
        end
        S_HMUL: begin
          prod_q  <= wt_q * vr_rdata_q;
          state_q <= S_HACC;
        end
        S_HACC: begin
          acc_q <= acc_sum;
          if (tap_k_q == 5'sd5) begin
            out_valid_o   <= 1'b1;
            blurred_o     <= scale_sat(acc_sum);
            out_row_o     <= 10'(emit_row_q);
            out_col_o     <= 10'(hx_q);
            frame_done_o  <= emit_row_end && (hx_q == w_cl - ColW'(1));
            last_of_run_o <= (hx_q == hlast_q);
            state_q       <= S_OUT;
          end else begin
            tap_k_q <= tap_k_q + 5'sd1;
            state_q <= S_HADDR;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            if (hx_q == hlast_q) begin
              state_q <= S_FIN;
            end else begin
              hx_q    <= hx_q + ColW'(1);
              tap_k_q <= -5'sd5;
              acc_q   <= '0;
              state_q <= S_HADDR;
            end
          end
        end
        S_FIN: begin
          if (is_pixel_q) begin
            if (in_col_wrap) begin
              in_col_q <= '0;
              in_row_q <= in_row_q + RowW'(1);
              in_m10_q <= (in_m10_q == 4'(StoreRows - 1)) ? 4'd0 : in_m10_q + 4'd1;
            end else begin
              in_col_q <= in_col_q + ColW'(1);
            end
          end
          if (did_vert_q) begin
            if (!is_pixel_q && emit_col_wrap && emit_row_end) begin
              // last drain request: back to the frame start
              in_row_q   <= '0;
              in_col_q   <= '0;
              in_m10_q   <= '0;
              emit_row_q <= '0;
              emit_col_q <= '0;
              emit_m10_q <= '0;
            end else if (emit_col_wrap) begin
              emit_col_q <= '0;
              emit_row_q <= emit_row_q + RowW'(1);
              emit_m10_q <= (emit_m10_q == 4'(StoreRows - 1)) ? 4'd0 : emit_m10_q + 4'd1;
            end else begin
              emit_col_q <= emit_col_q + ColW'(1);
            end
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SGB_ASSERT_NOW(a_out_only_in_out_state, out_valid_o, state_q == S_OUT)
  `SGB_ASSERT_NOW(a_slot_in_range, state_q == S_VADDR, rs_m10 < 4'(StoreRows))
  `SGB_ASSERT_NOW(a_in_slot_range, 1'b1, in_m10_q < 4'(StoreRows) && emit_m10_q < 4'(StoreRows))
  `SGB_ASSERT_NEXT(a_size_write_restarts,
      cfg_valid_i && cfg_ready_o && (cfg_index_i == RegWidth || cfg_index_i == RegHeight),
      in_row_q == '0 && emit_row_q == '0 && in_col_q == '0)

endmodule
